// File: hdl/nearest_peak_match_purge_assert.svh
// assertion macros used by npm_dp.sv
`ifndef NEAREST_PEAK_MATCH_PURGE_ASSERT_SVH
`define NEAREST_PEAK_MATCH_PURGE_ASSERT_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define NPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define NPM_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define NPM_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/npm_pkg.sv
`default_nettype none

package npm_pkg;

  // sizes fixed by the transaction fields
  localparam int unsigned MAX_PEAKS_DEF    = 1024;
  localparam int unsigned PIXEL_INDEX_BITS = 24;
  localparam int unsigned WIDTH_BITS       = 13;
  localparam int unsigned COL_BITS         = 12;
  localparam int unsigned THR_BITS         = 49;
  localparam int unsigned DIST_BITS        = 50;
  localparam int unsigned SLOT_OUT_BITS    = 10;
  localparam int unsigned SQ_BITS          = 2 * PIXEL_INDEX_BITS + 1;
  localparam int unsigned CFG_IDX_BITS     = 2;
  localparam int unsigned CFG_DATA_BITS    = 49;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_THR   = 2'd1;

  // image width limits and reset value
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 13'd64;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = 13'd4096;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = 13'd1;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [PIXEL_INDEX_BITS-1:0] pixel_index;
    logic                        entry_valid;
  } npm_in_t;

  typedef struct packed {
    logic                     matched;
    logic [SLOT_OUT_BITS-1:0] slot;
    logic [DIST_BITS-1:0]     distance_sq;
    logic                     table_full;
  } npm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } npm_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic scan_start;
    logic scan_step;
    logic emit;
  } npm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic is_query;
    logic table_empty;
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } npm_stat_t;

endpackage

`default_nettype wire

// File: hdl/npm_div.sv
`default_nettype none

module npm_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [npm_pkg::PIXEL_INDEX_BITS-1:0] dividend_i,
  input  logic [npm_pkg::WIDTH_BITS-1:0]       divisor_i,
  output logic                                 done_o,
  output logic [npm_pkg::PIXEL_INDEX_BITS-1:0] quotient_o,
  output logic [npm_pkg::COL_BITS-1:0]         remainder_o
);
  import npm_pkg::*;

  localparam int unsigned CntBits = $clog2(PIXEL_INDEX_BITS + 1);

  logic [CntBits-1:0]          cnt_q;
  logic [PIXEL_INDEX_BITS-1:0] quo_q;
  logic [COL_BITS-1:0]         rem_q;
  logic [WIDTH_BITS-1:0]       dvs_q;
  logic [WIDTH_BITS-1:0]       trial;
  logic [WIDTH_BITS-1:0]       diff;
  logic                        fits;

  // one restoring step per cycle, msb first
  assign trial = {rem_q, quo_q[PIXEL_INDEX_BITS-1]};
  assign fits  = trial >= dvs_q;
  assign diff  = trial - dvs_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntBits'(PIXEL_INDEX_BITS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntBits'(1);
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[PIXEL_INDEX_BITS-2:0], fits};
      rem_q <= fits ? diff[COL_BITS-1:0] : trial[COL_BITS-1:0];
    end
  end

  assign done_o      = (cnt_q == CntBits'(1));
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: hdl/npm_dp.sv
`default_nettype none
`include "nearest_peak_match_purge_assert.svh"

module npm_dp #(
  parameter int unsigned MAX_PEAKS = npm_pkg::MAX_PEAKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [npm_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [npm_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  npm_pkg::npm_in_t                 in_data_i,
  input  npm_pkg::npm_cmd_t                cmd_i,
  output npm_pkg::npm_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output npm_pkg::npm_out_t                out_data_o
);
  import npm_pkg::*;

  localparam int unsigned SlotBits = $clog2(MAX_PEAKS);
  localparam int unsigned CntBits  = $clog2(MAX_PEAKS + 1);
  localparam int unsigned DxBits   = COL_BITS;
  localparam int unsigned DyBits   = PIXEL_INDEX_BITS;

  // configuration registers
  logic [WIDTH_BITS-1:0] image_width_q;
  logic [THR_BITS-1:0]   thr_q;
  logic [WIDTH_BITS-1:0] eff_w;

  // item registers
  logic [1:0] kind_q;
  logic       ev_q;

  // divider results
  logic                        div_done;
  logic [PIXEL_INDEX_BITS-1:0] div_quo;
  logic [COL_BITS-1:0]         div_rem;

  // table
  logic [COL_BITS-1:0]         col_mem  [MAX_PEAKS];
  logic [PIXEL_INDEX_BITS-1:0] row_mem  [MAX_PEAKS];
  logic                        live_mem [MAX_PEAKS];
  logic [CntBits-1:0]          count_q;
  logic                        full;
  logic                        load_we;
  logic                        purge_we;
  logic [SlotBits-1:0]         live_addr;

  // scan pipeline
  logic [CntBits-1:0]          scan_ptr_q;
  logic                        p1_vld_q, p2_vld_q, p3_vld_q;
  logic [SlotBits-1:0]         p1_slot_q, p2_slot_q, p3_slot_q;
  logic [COL_BITS-1:0]         rd_col_q;
  logic [PIXEL_INDEX_BITS-1:0] rd_row_q;
  logic                        rd_live_q;
  logic [DxBits-1:0]           dx_q;
  logic [DyBits-1:0]           dy_q;
  logic [2*DxBits-1:0]         sx_q;
  logic [2*DyBits-1:0]         sy_q;
  logic [SQ_BITS-1:0]          d_sum;

  // nearest so far
  logic                found_q;
  logic [SlotBits-1:0] best_slot_q;
  logic [SQ_BITS-1:0]  best_d_q;
  logic                hit;

  // result register
  npm_out_t out_d;
  npm_out_t out_q;
  logic     out_vld_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WIDTH_RESET;
      thr_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: image_width_q <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_MATCH_THR:   thr_q         <= cfg_data_i[THR_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // width clamped to the supported range
  always_comb begin
    if (image_width_q == '0) begin
      eff_w = WIDTH_MIN;
    end else if (image_width_q > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = image_width_q;
    end
  end

  // latch the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_data_i.kind;
      ev_q   <= in_data_i.entry_valid;
    end
  end

  // index to column and row
  npm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (in_data_i.pixel_index),
    .divisor_i   (eff_w),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // table writes happen when the result is handed out
  assign full      = (count_q == CntBits'(MAX_PEAKS));
  assign hit       = found_q && (best_d_q < thr_q);
  assign load_we   = cmd_i.emit && (kind_q == KIND_LOAD) && !full;
  assign purge_we  = cmd_i.emit && (kind_q == KIND_QUERY) && hit;
  assign live_addr = purge_we ? best_slot_q : count_q[SlotBits-1:0];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      col_mem[count_q[SlotBits-1:0]] <= div_rem;
      row_mem[count_q[SlotBits-1:0]] <= div_quo;
    end
    if (load_we || purge_we) begin
      live_mem[live_addr] <= load_we ? ev_q : 1'b0;
    end
  end

  // registered table read for the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      rd_col_q  <= col_mem[scan_ptr_q[SlotBits-1:0]];
      rd_row_q  <= row_mem[scan_ptr_q[SlotBits-1:0]];
      rd_live_q <= live_mem[scan_ptr_q[SlotBits-1:0]];
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.emit && (kind_q == KIND_CLEAR)) begin
      count_q <= '0;
    end else if (load_we) begin
      count_q <= count_q + CntBits'(1);
    end
  end

  // scan pointer and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ptr_q <= '0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      p3_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_ptr_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_ptr_q <= scan_ptr_q + CntBits'(1);
      end
      p1_vld_q <= cmd_i.scan_step;
      p2_vld_q <= p1_vld_q && rd_live_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  // absolute differences, then squares
  always_ff @(posedge clk_i) begin
    p1_slot_q <= scan_ptr_q[SlotBits-1:0];
    p2_slot_q <= p1_slot_q;
    p3_slot_q <= p2_slot_q;
    dx_q <= (div_rem > rd_col_q) ? div_rem - rd_col_q : rd_col_q - div_rem;
    dy_q <= (div_quo > rd_row_q) ? div_quo - rd_row_q : rd_row_q - div_quo;
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
  end

  assign d_sum = SQ_BITS'(sx_q) + SQ_BITS'(sy_q);

  // keep the first strict minimum so the lowest slot wins a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_start || cmd_i.accept) begin
      found_q <= 1'b0;
    end else if (p3_vld_q) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_vld_q && (!found_q || (d_sum < best_d_q))) begin
      best_slot_q <= p3_slot_q;
      best_d_q    <= d_sum;
    end
  end

  // result fields
  always_comb begin
    out_d = '0;
    case (kind_q)
      KIND_LOAD: begin
        if (full) begin
          out_d.table_full = 1'b1;
        end else begin
          out_d.slot = SLOT_OUT_BITS'(count_q);
        end
      end
      KIND_QUERY: begin
        if (found_q) begin
          out_d.slot        = SLOT_OUT_BITS'(best_slot_q);
          out_d.distance_sq = DIST_BITS'(best_d_q);
          out_d.matched     = hit;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // status to the controller
  assign stat_o.div_done    = div_done;
  assign stat_o.is_query    = (kind_q == KIND_QUERY);
  assign stat_o.table_empty = (count_q == '0);
  assign stat_o.scan_last   = (scan_ptr_q == count_q - CntBits'(1));
  assign stat_o.pipe_empty  = !p1_vld_q && !p2_vld_q && !p3_vld_q;
  assign stat_o.out_free    = !out_vld_q || !out_stall_i;

  `NPM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntBits'(MAX_PEAKS), "count above depth")
  `NPM_ASSERT(a_emit_free, clk_i, rst_ni, cmd_i.emit |-> stat_o.out_free, "result overwritten")
  `NPM_ASSERT(a_scan_range, clk_i, rst_ni, cmd_i.scan_step |-> (scan_ptr_q < count_q), "scan past fill")
  `NPM_ASSERT(a_one_write, clk_i, rst_ni, !(load_we && purge_we), "load and purge together")
  `NPM_ASSERT_RST(a_reset_out, clk_i, !rst_ni |=> !out_vld_q, "output valid in reset")

endmodule

`default_nettype wire

// File: hdl/npm_ctrl.sv
`default_nettype none

module npm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_kind_i,
  output logic               in_stall_o,
  input  npm_pkg::npm_stat_t stat_i,
  output npm_pkg::npm_cmd_t  cmd_o
);
  import npm_pkg::*;

  npm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if ((in_kind_i == KIND_LOAD) || (in_kind_i == KIND_QUERY)) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIVIDE;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_DIVIDE: begin
        if (stat_i.div_done) begin
          if (stat_i.is_query) begin
            cmd_o.scan_start = 1'b1;
            state_d          = stat_i.table_empty ? ST_DRAIN : ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.pipe_empty) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/nearest_peak_match_purge.sv
// nearest peak match and purge
// input channel: in_valid_i / in_stall_o with in_data_i (kind, pixel_index,
// entry_valid); output channel: out_valid_o / out_stall_i with out_data_o.
// a load splits the index into column and row and appends it to the table;
// a query finds the nearest live entry (lowest slot on a tie) and, when its
// squared distance is below match_threshold_sq, marks it dead; clear empties.
// one transaction is worked on at a time. clear and unknown kinds go straight
// to the result; a load or query first runs the bit-per-cycle index divider,
// and a query then scans the entries loaded since the last clear, one table
// read per cycle, through the read, difference, square and compare stages.
// the next transaction is taken while a finished result waits in the output
// register; a stalled receiver holds that result and, once the next one is
// done, the block waits with in_stall_o high until the register frees.
// reset empties the table at once (fill count to zero), sets image_width to
// 64 and the threshold to 0. the user must write the config port only while
// idle; the block itself does not enforce it.
`default_nettype none

module nearest_peak_match_purge #(
  parameter int unsigned MAX_PEAKS = npm_pkg::MAX_PEAKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [npm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [npm_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  npm_pkg::npm_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output npm_pkg::npm_out_t                 out_data_o
);
  import npm_pkg::*;

  npm_cmd_t  cmd;
  npm_stat_t stat;

  // sequencer
  npm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, divider and scan pipeline
  npm_dp #(
    .MAX_PEAKS (MAX_PEAKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import npm_pkg::*;

  localparam int unsigned PEAKS       = MAX_PEAKS_DEF;
  localparam int unsigned RAND_ITEMS  = 580;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned END_WAIT    = 64;
  localparam int unsigned LIMIT       = 2_000_000;

  // codes the package leaves unnamed
  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam logic [1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [1:0] CFG_UNMAPPED_HI = 2'd3;

  localparam logic [48:0] THR_ALL_ONES = 49'h1_FFFF_FFFF_FFFF;
  localparam longint unsigned DIST_SAT = (64'd1 << DIST_BITS) - 1;

  localparam npm_out_t NO_REPORT   = '0;
  localparam npm_out_t FULL_REPORT = '{1'b0, 10'd0, 50'd0, 1'b1};

  // one directed row: a register write or a transaction, with an optional fixed result
  typedef struct packed {
    bit          cfg;
    logic [1:0]  sel;
    logic [48:0] val;
    logic        valid;
    bit          typed;
    npm_out_t    want;
  } step_t;

  localparam int PLAN_LEN = 28;
  localparam step_t PLAN [PLAN_LEN] = '{
    '{1'b0, KIND_QUERY,      49'd0,        1'b0, 1'b1, NO_REPORT},
    '{1'b0, KIND_UNUSED,     49'hFFFFFF,   1'b1, 1'b1, NO_REPORT},
    '{1'b0, KIND_CLEAR,      49'd0,        1'b0, 1'b1, NO_REPORT},
    '{1'b0, KIND_LOAD,       49'd0,        1'b1, 1'b1, '{1'b0, 10'd0, 50'd0, 1'b0}},
    '{1'b0, KIND_LOAD,       49'hFFFFFF,   1'b1, 1'b1, '{1'b0, 10'd1, 50'd0, 1'b0}},
    '{1'b0, KIND_LOAD,       49'd130,      1'b0, 1'b1, '{1'b0, 10'd2, 50'd0, 1'b0}},
    '{1'b0, KIND_LOAD,       49'd65,       1'b1, 1'b1, '{1'b0, 10'd3, 50'd0, 1'b0}},
    '{1'b0, KIND_LOAD,       49'd65,       1'b1, 1'b1, '{1'b0, 10'd4, 50'd0, 1'b0}},
    // equal distances to two entries, then a zero distance that a zero threshold does not match
    '{1'b0, KIND_QUERY,      49'd130,      1'b1, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'hFFFFFF,   1'b0, 1'b0, NO_REPORT},
    '{1'b1, CFG_MATCH_THR,   49'd3,        1'b0, 1'b0, NO_REPORT},
    // purge both tied entries, then a miss, then purge the rest
    '{1'b0, KIND_QUERY,      49'd130,      1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'd130,      1'b1, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'd130,      1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'hFFFFFF,   1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'd0,        1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'd130,      1'b0, 1'b1, NO_REPORT},
    '{1'b1, CFG_UNMAPPED_LO, THR_ALL_ONES, 1'b0, 1'b0, NO_REPORT},
    '{1'b1, CFG_UNMAPPED_HI, 49'h0_5555_AAAA_5555, 1'b0, 1'b0, NO_REPORT},
    // width zero behaves as one: rows become the whole index
    '{1'b1, CFG_IMAGE_WIDTH, 49'd0,        1'b0, 1'b0, NO_REPORT},
    '{1'b1, CFG_MATCH_THR,   THR_ALL_ONES, 1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_LOAD,       49'hFFFFFF,   1'b1, 1'b1, '{1'b0, 10'd5, 50'd0, 1'b0}},
    '{1'b0, KIND_QUERY,      49'd0,        1'b1, 1'b0, NO_REPORT},
    // width above the maximum behaves as the maximum
    '{1'b1, CFG_IMAGE_WIDTH, 49'd8191,     1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_LOAD,       49'hFFFFFF,   1'b1, 1'b1, '{1'b0, 10'd6, 50'd0, 1'b0}},
    '{1'b0, KIND_QUERY,      49'd0,        1'b0, 1'b0, NO_REPORT},
    '{1'b0, KIND_QUERY,      49'hABCDEF,   1'b1, 1'b1, NO_REPORT},
    '{1'b0, KIND_CLEAR,      49'hFFFFFF,   1'b1, 1'b1, NO_REPORT}
  };

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  npm_in_t                  in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  npm_out_t                 out_data;

  // shadow of the peak table and the registers
  longint unsigned pk_col   [PEAKS];
  longint unsigned pk_row   [PEAKS];
  bit              pk_alive [PEAKS];
  int unsigned     pk_fill   = 0;
  logic [12:0]     cur_width = 13'd64;
  logic [48:0]     cur_thr   = '0;

  npm_out_t    awaited_reports [$];
  int unsigned spots [$];

  bit          idle_on   = 1'b1;
  bit          hold_ask  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;
  int unsigned errors    = 0;
  int unsigned checked   = 0;
  int unsigned useful    = 0;
  int unsigned n_load = 0, n_drop = 0, n_query = 0, n_purge = 0;
  int unsigned n_clear = 0, n_unknown = 0, n_writes = 0;

  nearest_peak_match_purge DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: run limit reached with %0d reports outstanding", $time,
               awaited_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint unsigned eff_width();
    if (cur_width < WIDTH_MIN) return WIDTH_MIN;
    if (cur_width > WIDTH_MAX) return WIDTH_MAX;
    return cur_width;
  endfunction

  // nearest live peak search with purge, updates the shadow table
  function automatic npm_out_t report_for(npm_in_t item);
    npm_out_t        r;
    longint unsigned w, pix, qc, qr, dx, dy, d, best_d;
    int unsigned     best;
    bit              found;
    r = NO_REPORT;
    w = eff_width();
    pix = longint'(item.pixel_index);
    found = 1'b0;
    best = 0;
    best_d = 0;
    case (item.kind)
      KIND_LOAD: begin
        n_load++;
        if (pk_fill >= PEAKS) begin
          r.table_full = 1'b1;
          n_drop++;
        end else begin
          pk_col[pk_fill] = pix % w;
          pk_row[pk_fill] = pix / w;
          pk_alive[pk_fill] = item.entry_valid;
          r.slot = 10'(pk_fill);
          pk_fill++;
        end
      end
      KIND_QUERY: begin
        n_query++;
        qc = pix % w;
        qr = pix / w;
        for (int unsigned j = 0; j < pk_fill; j++) begin
          if (pk_alive[j]) begin
            dx = (qc > pk_col[j]) ? qc - pk_col[j] : pk_col[j] - qc;
            dy = (qr > pk_row[j]) ? qr - pk_row[j] : pk_row[j] - qr;
            d = dx * dx + dy * dy;
            if (d > DIST_SAT) d = DIST_SAT;
            if (!found || d < best_d) begin
              found = 1'b1;
              best = j;
              best_d = d;
            end
          end
        end
        if (found) begin
          r.slot = 10'(best);
          r.distance_sq = best_d[DIST_BITS-1:0];
          if (best_d < longint'(cur_thr)) begin
            pk_alive[best] = 1'b0;
            r.matched = 1'b1;
            n_purge++;
          end
        end
      end
      KIND_CLEAR: begin
        n_clear++;
        foreach (pk_alive[j]) pk_alive[j] = 1'b0;
        pk_fill = 0;
      end
      default: n_unknown++;
    endcase
    return r;
  endfunction

  // index close to a stored peak: up to three pixels along the row, the same row or one row up or down
  function automatic logic [23:0] near_spot();
    longint unsigned base, w;
    if (spots.size() == 0) return 24'($urandom);
    w = eff_width();
    base = spots[$urandom_range(spots.size() - 1)];
    base = base + (64'd1 << 24) - 3 - w + $urandom_range(6) + w * $urandom_range(2);
    return base[23:0];
  endfunction

  // offer one transaction, predict its report once it is taken
  task automatic push_item(logic [1:0] kind, logic [23:0] pix, logic valid,
                           bit typed, npm_out_t want);
    npm_out_t calc;
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind, pix, valid};
    do @(posedge clk); while (in_stall !== 1'b0);
    calc = report_for(in_data);
    awaited_reports.push_back(typed ? want : calc);
    if (kind != KIND_UNUSED) useful++;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding report
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [48:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_IMAGE_WIDTH) cur_width = data[12:0];
    else if (idx == CFG_MATCH_THR) cur_thr = data;
    n_writes++;
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 7);
    end
  end

  // report checker
  always @(posedge clk) begin
    npm_out_t want;
    bit       bad;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      bad = 1'b0;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected report expected none got %p", $time, out_data);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        checked++;
        if (out_data.matched !== want.matched) begin
          $display("%0t: matched expected %0d got %0d", $time, want.matched,
                   out_data.matched);
          bad = 1'b1;
        end
        if (out_data.slot !== want.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, want.slot, out_data.slot);
          bad = 1'b1;
        end
        if (out_data.distance_sq !== want.distance_sq) begin
          $display("%0t: distance_sq expected %0d got %0d", $time, want.distance_sq,
                   out_data.distance_sq);
          bad = 1'b1;
        end
        if (out_data.table_full !== want.table_full) begin
          $display("%0t: table_full expected %0d got %0d", $time, want.table_full,
                   out_data.table_full);
          bad = 1'b1;
        end
        if (bad) errors++;
      end
    end
  end

  initial begin
    int unsigned round, pick, goal;
    logic [12:0] wv;
    logic [63:0] tv;
    logic [23:0] px;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].cfg) begin
        settle();
        write_reg(PLAN[i].sel, PLAN[i].val);
      end else begin
        push_item(PLAN[i].sel, PLAN[i].val[23:0], PLAN[i].valid, PLAN[i].typed,
                  PLAN[i].want);
      end
    end

    // fill the whole table, then loads past the end are dropped
    settle();
    write_reg(CFG_IMAGE_WIDTH, 49'($urandom_range(1, 4096)));
    write_reg(CFG_MATCH_THR, 49'd0);
    push_item(KIND_CLEAR, 24'd0, 1'b0, 1'b0, NO_REPORT);
    repeat (PEAKS) push_item(KIND_LOAD, 24'($urandom), $urandom_range(7) != 0,
                             1'b0, NO_REPORT);
    push_item(KIND_LOAD, 24'($urandom), 1'b1, 1'b1, FULL_REPORT);
    settle();
    write_reg(CFG_MATCH_THR, THR_ALL_ONES);
    push_item(KIND_QUERY, 24'($urandom), 1'b0, 1'b0, NO_REPORT);
    push_item(KIND_LOAD, 24'($urandom), 1'b1, 1'b1, FULL_REPORT);
    push_item(KIND_CLEAR, 24'($urandom), 1'b1, 1'b1, NO_REPORT);

    // random rounds, each under its own register setting
    goal = useful + RAND_ITEMS;
    round = 0;
    while (useful < goal) begin
      round++;
      settle();
      case ($urandom_range(5))
        0: wv = 13'd0;
        1: wv = 13'd1;
        2: wv = WIDTH_MAX;
        3: wv = 13'h1FFF;
        4: wv = 13'($urandom_range(2, 4095));
        default: wv = 13'($urandom_range(4097, 8191));
      endcase
      write_reg(CFG_IMAGE_WIDTH, 49'(wv));
      tv = {$urandom, $urandom};
      case ($urandom_range(4))
        0: tv = 64'd0;
        1: tv = 64'(THR_ALL_ONES);
        2: tv = 64'(tv[48:0] >> $urandom_range(48));
        default: tv = 64'($urandom_range(1, 64));
      endcase
      write_reg(CFG_MATCH_THR, tv[48:0]);
      idle_on = (round != 3);
      // receiver holds off while loads keep coming
      if (round == 2) hold_ask = 1'b1;
      if (pk_fill > 40 || $urandom_range(3) != 0) begin
        push_item(KIND_CLEAR, 24'($urandom), $urandom_range(1), 1'b0, NO_REPORT);
        spots.delete();
      end
      repeat ($urandom_range(1, 24)) begin
        px = ($urandom_range(1) != 0) ? near_spot() : 24'($urandom);
        spots.push_back(px);
        push_item(KIND_LOAD, px, $urandom_range(9) != 0, 1'b0, NO_REPORT);
      end
      repeat ($urandom_range(4, 30)) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          push_item(KIND_QUERY, near_spot(), $urandom_range(1), 1'b0, NO_REPORT);
        end else if (pick < 80) begin
          push_item(KIND_QUERY, 24'($urandom), $urandom_range(1), 1'b0, NO_REPORT);
        end else if (pick < 88) begin
          px = near_spot();
          spots.push_back(px);
          push_item(KIND_LOAD, px, $urandom_range(3) != 0, 1'b0, NO_REPORT);
        end else if (pick < 93) begin
          push_item(KIND_UNUSED, 24'($urandom), $urandom_range(1), 1'b0, NO_REPORT);
        end else if (pick < 96) begin
          push_item(KIND_CLEAR, 24'($urandom), $urandom_range(1), 1'b0, NO_REPORT);
          spots.delete();
        end else begin
          // sender waits for the pipeline to empty
          settle();
        end
      end
    end
    idle_on = 1'b1;

    settle();
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d loads (%0d dropped when full), %0d queries (%0d purges),",
             n_load, n_drop, n_query, n_purge);
    $display("  %0d clears, %0d unknown kinds, %0d register writes, %0d reports checked",
             n_clear, n_unknown, n_writes, checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
